// ===== src/sru_pkg.sv =====
// Shared types and constants for the x86 group-2 shift and rotate unit.
// Depends on nothing; every other file of the unit refers to it by scoped names.
package sru_pkg;

    // Operation codes
    localparam logic [2:0] OP_ROL = 3'd0;
    localparam logic [2:0] OP_ROR = 3'd1;
    localparam logic [2:0] OP_RCL = 3'd2;
    localparam logic [2:0] OP_RCR = 3'd3;
    localparam logic [2:0] OP_SHL = 3'd4;
    localparam logic [2:0] OP_SHR = 3'd5;
    localparam logic [2:0] OP_SAR = 3'd6;

    localparam int unsigned DATA_W  = 16;
    localparam int unsigned COUNT_W = 8;

    localparam logic [DATA_W-1:0] WORD_SIGN = 16'h8000;
    localparam logic [DATA_W-1:0] BYTE_SIGN = 16'h0080;
    localparam logic [DATA_W-1:0] WORD_MASK = 16'hFFFF;
    localparam logic [DATA_W-1:0] BYTE_MASK = 16'h00FF;

    // Request fields as captured at the input handshake
    typedef struct packed {
        logic [2:0]         operation;
        logic               wide;
        logic               count_mode;
        logic [DATA_W-1:0]  operand_value;
        logic [COUNT_W-1:0] shift_count;
        logic               carry_in;
        logic               overflow_in;
        logic               sign_in;
        logic               zero_in;
        logic               parity_in;
    } t_req;

    // Result fields presented on the output channel
    typedef struct packed {
        logic [DATA_W-1:0] result_value;
        logic              carry_out;
        logic              overflow_out;
        logic              sign_out;
        logic              zero_out;
        logic              parity_out;
    } t_result;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic cnt_zero;
    } t_status;

endpackage

// ===== src/sru_if.sv =====
// Valid/ready channel interfaces for the shift and rotate unit.
// Depends on sru_pkg for the data width constants.
interface sru_req_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  operation;
    logic                        wide;
    logic                        count_mode;
    logic [sru_pkg::DATA_W-1:0]  operand_value;
    logic [sru_pkg::COUNT_W-1:0] shift_count;
    logic                        carry_in;
    logic                        overflow_in;
    logic                        sign_in;
    logic                        zero_in;
    logic                        parity_in;

    modport source (
        output valid, operation, wide, count_mode, operand_value, shift_count,
               carry_in, overflow_in, sign_in, zero_in, parity_in,
        input  ready
    );
    modport sink (
        input  valid, operation, wide, count_mode, operand_value, shift_count,
               carry_in, overflow_in, sign_in, zero_in, parity_in,
        output ready
    );
endinterface

interface sru_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [sru_pkg::DATA_W-1:0] result_value;
    logic                       carry_out;
    logic                       overflow_out;
    logic                       sign_out;
    logic                       zero_out;
    logic                       parity_out;

    modport source (
        output valid, result_value, carry_out, overflow_out, sign_out, zero_out,
               parity_out,
        input  ready
    );
    modport sink (
        input  valid, result_value, carry_out, overflow_out, sign_out, zero_out,
               parity_out,
        output ready
    );
endinterface

// ===== src/sru_datapath.sv =====
// Datapath of the shift and rotate unit: operand, count and flag registers
// with a one-bit-position shifter. Depends on sru_pkg.
module sru_datapath (
    input  logic             i_clk,
    input  sru_pkg::t_req    i_req,
    input  sru_pkg::t_cmd    i_cmd,
    output sru_pkg::t_status o_status,
    output sru_pkg::t_result o_result
);

    logic [sru_pkg::DATA_W-1:0]  r_val,   n_val;
    logic [sru_pkg::COUNT_W-1:0] r_cnt,   n_cnt;
    logic [2:0]                  r_op;
    logic                        r_wide;
    logic                        r_single;
    logic                        r_active;
    logic                        r_old_msb;
    logic                        r_cf, n_cf;
    logic                        r_of, n_of;
    logic                        r_sf, n_sf;
    logic                        r_zf, n_zf;
    logic                        r_pf, n_pf;

    logic [sru_pkg::DATA_W-1:0]  msb;
    logic [sru_pkg::DATA_W-1:0]  mask;
    logic [sru_pkg::DATA_W-1:0]  step_val;
    logic                        step_cf;
    logic                        top_bit;
    logic                        low_bit;
    logic                        new_msb;
    logic [sru_pkg::DATA_W-1:0]  ld_mask;
    logic                        ld_active;

    assign msb     = r_wide ? sru_pkg::WORD_SIGN : sru_pkg::BYTE_SIGN;
    assign mask    = r_wide ? sru_pkg::WORD_MASK : sru_pkg::BYTE_MASK;
    assign top_bit = |(r_val & msb);
    assign low_bit = r_val[0];
    assign new_msb = |(r_val & msb);

    assign ld_mask   = i_req.wide ? sru_pkg::WORD_MASK : sru_pkg::BYTE_MASK;
    assign ld_active = (i_req.operation <= sru_pkg::OP_SAR) &&
                       (!i_req.count_mode || (i_req.shift_count != '0));

    // One bit position of the selected operation
    always_comb begin
        step_val = r_val;
        step_cf  = r_cf;
        case (r_op)
            sru_pkg::OP_ROL: begin
                step_val = ((r_val << 1) & mask) | {{(sru_pkg::DATA_W-1){1'b0}}, top_bit};
                step_cf  = top_bit;
            end
            sru_pkg::OP_ROR: begin
                step_val = (r_val >> 1) | (low_bit ? msb : '0);
                step_cf  = low_bit;
            end
            sru_pkg::OP_RCL: begin
                step_val = ((r_val << 1) & mask) | {{(sru_pkg::DATA_W-1){1'b0}}, r_cf};
                step_cf  = top_bit;
            end
            sru_pkg::OP_RCR: begin
                step_val = (r_val >> 1) | (r_cf ? msb : '0);
                step_cf  = low_bit;
            end
            sru_pkg::OP_SHL: begin
                step_val = (r_val << 1) & mask;
                step_cf  = top_bit;
            end
            sru_pkg::OP_SHR: begin
                step_val = r_val >> 1;
                step_cf  = low_bit;
            end
            default: begin
                step_val = (r_val >> 1) | (r_val & msb);
                step_cf  = low_bit;
            end
        endcase
    end

    // Load, advance or settle the flags
    always_comb begin
        n_val = r_val;
        n_cnt = r_cnt;
        n_cf  = r_cf;
        n_of  = r_of;
        n_sf  = r_sf;
        n_zf  = r_zf;
        n_pf  = r_pf;
        if (i_cmd.load) begin
            n_val = i_req.operand_value & ld_mask;
            n_cf  = i_req.carry_in;
            n_of  = i_req.overflow_in;
            n_sf  = i_req.sign_in;
            n_zf  = i_req.zero_in;
            n_pf  = i_req.parity_in;
            if (!ld_active) begin
                n_cnt = '0;
            end else if (i_req.count_mode) begin
                n_cnt = i_req.shift_count;
            end else begin
                n_cnt = sru_pkg::COUNT_W'(1);
            end
        end else if (i_cmd.step) begin
            n_val = step_val & mask;
            n_cf  = step_cf;
            n_cnt = r_cnt - sru_pkg::COUNT_W'(1);
        end else if (i_cmd.finish && r_active) begin
            if (r_single) begin
                n_of = (r_op == sru_pkg::OP_SAR) ? 1'b0 : (r_old_msb ^ new_msb);
            end
            if (r_op >= sru_pkg::OP_SHL) begin
                n_sf = new_msb;
                n_zf = (r_val == '0);
                n_pf = ~^r_val[7:0];
            end
        end
    end

    // Hold the working registers
    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_cnt <= n_cnt;
        r_cf  <= n_cf;
        r_of  <= n_of;
        r_sf  <= n_sf;
        r_zf  <= n_zf;
        r_pf  <= n_pf;
        if (i_cmd.load) begin
            r_op      <= i_req.operation;
            r_wide    <= i_req.wide;
            r_single  <= !i_req.count_mode;
            r_active  <= ld_active;
            r_old_msb <= i_req.wide ? i_req.operand_value[15] : i_req.operand_value[7];
        end
    end

    assign o_status.cnt_zero = (r_cnt == '0);

    assign o_result.result_value = r_val;
    assign o_result.carry_out    = r_cf;
    assign o_result.overflow_out = r_of;
    assign o_result.sign_out     = r_sf;
    assign o_result.zero_out     = r_zf;
    assign o_result.parity_out   = r_pf;

endmodule

// ===== src/sru_ctrl.sv =====
// Controller of the shift and rotate unit: takes a request, steps the
// datapath until the count runs out, then offers the result. Depends on sru_pkg.
module sru_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  sru_pkg::t_status i_status,
    output sru_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Commands and next state
    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        o_cmd.load   = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.finish = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (i_status.cnt_zero) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_out_valid = 1'b0;
                n_state     = S_IDLE;
            end
        endcase
    end

    // Hold state and the output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== src/x86_shift_rotate_unit_top.sv =====
// Shift and rotate unit for the 8086 group-2 instructions (ROL, ROR, RCL, RCR,
// SHL, SHR, SAR) on byte or word operands, one request at a time. The shifter
// moves the operand one bit position per cycle, once for each unit of the count
// register: the shift count, up to 255, in count mode, one for shift-by-one,
// and none for a count of zero or an undefined operation. The result waits in
// the output registers until taken, and the next request is accepted in the
// cycle after that.
// Depends on sru_pkg, sru_if, sru_ctrl and sru_datapath.
module x86_shift_rotate_unit_top (
    input  logic     i_clk,
    input  logic     i_rst_n,
    sru_req_if.sink  i_req,
    sru_rsp_if.source o_rsp
);

    sru_pkg::t_req    req;
    sru_pkg::t_cmd    cmd;
    sru_pkg::t_status status;
    sru_pkg::t_result result;
    logic             in_ready;
    logic             out_valid;

    // Gather the request fields
    assign req.operation     = i_req.operation;
    assign req.wide          = i_req.wide;
    assign req.count_mode    = i_req.count_mode;
    assign req.operand_value = i_req.operand_value;
    assign req.shift_count   = i_req.shift_count;
    assign req.carry_in      = i_req.carry_in;
    assign req.overflow_in   = i_req.overflow_in;
    assign req.sign_in       = i_req.sign_in;
    assign req.zero_in       = i_req.zero_in;
    assign req.parity_in     = i_req.parity_in;

    sru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    sru_datapath u_datapath (
        .i_clk    (i_clk),
        .i_req    (req),
        .i_cmd    (cmd),
        .o_status (status),
        .o_result (result)
    );

    // Drive the channels
    assign i_req.ready        = in_ready;
    assign o_rsp.valid        = out_valid;
    assign o_rsp.result_value = result.result_value;
    assign o_rsp.carry_out    = result.carry_out;
    assign o_rsp.overflow_out = result.overflow_out;
    assign o_rsp.sign_out     = result.sign_out;
    assign o_rsp.zero_out     = result.zero_out;
    assign o_rsp.parity_out   = result.parity_out;

    // A request is never taken while a result is on offer
    a_ready_excl_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_ready && out_valid))
        else $error("request accepted while a result is pending");

    // Every step has count left to consume
    a_step_needs_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step |-> !status.cnt_zero)
        else $error("shifter stepped past the end of the count");

    // An accepted request closes the input until its result is taken
    a_accept_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && in_ready) |=> !in_ready)
        else $error("input stayed open after a request was accepted");

    // A finished result stays on offer until it is taken
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !o_rsp.ready) |=> (out_valid && $stable(result)))
        else $error("result changed or dropped before it was taken");

endmodule
